[rtl/core/dtrie_pkg.sv]
package dtrie_pkg;

    // fixed field widths
    localparam int DIGIT_W = 4;
    localparam int USED_W  = 11;

    // controller to datapath
    typedef struct packed {
        logic clear;    // write zero at the sweep address
        logic accept;   // take a word, launch the child read
        logic resolve;  // finish the digit, update walk state
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_done;     // sweep reaches its last entry this cycle
        logic out_blocked;  // last digit waits on a full, stalled result register
    } t_ctrl_stat;

endpackage

[rtl/core/dtrie_ctrl.sv]
module dtrie_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  dtrie_pkg::t_ctrl_stat i_stat,
    output dtrie_pkg::t_ctrl_cmd  o_cmd,
    output logic                  o_in_stall
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_WALK  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd.clear    = 1'b0;
        o_cmd.accept   = 1'b0;
        o_cmd.resolve  = 1'b0;
        o_in_stall     = 1'b1;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_WALK;
                end
            end
            S_WALK: begin
                // hold a last digit while the result register cannot take a new word
                if (!i_stat.out_blocked) begin
                    o_cmd.resolve = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/core/dtrie_dpath.sv]
module dtrie_dpath #(
    parameter int NODE_COUNT = 1024,
    parameter int RADIX      = 10
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  dtrie_pkg::t_ctrl_cmd               i_cmd,
    output dtrie_pkg::t_ctrl_stat              o_stat,
    input  logic                               i_mode,
    input  logic [dtrie_pkg::DIGIT_W-1:0]      i_digit,
    input  logic                               i_last,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_found,
    output logic                               o_pool_full,
    output logic [dtrie_pkg::USED_W-1:0]       o_nodes_used
);

    localparam int DEPTH = NODE_COUNT * RADIX;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(NODE_COUNT);
    localparam int CW    = $clog2(NODE_COUNT + 1);
    localparam int UW    = (CW > dtrie_pkg::USED_W) ? CW : dtrie_pkg::USED_W;

    logic [NW-1:0] mem [DEPTH];

    logic          r_mode;
    logic          r_last;
    logic          r_digit_ok;
    logic [AW-1:0] r_slot;
    logic [NW-1:0] r_rdata;
    logic [NW-1:0] r_cursor;
    logic [CW-1:0] r_next_free;
    logic          r_missed;
    logic          r_ovf;
    logic [AW-1:0] r_clr_addr;
    logic          r_out_valid;
    logic          r_out_found;
    logic          r_out_full;
    logic [dtrie_pkg::USED_W-1:0] r_out_used;

    logic [NW-1:0] n_cursor;
    logic [CW-1:0] n_next_free;
    logic          n_missed;
    logic          n_ovf;
    logic          walk_we;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [NW-1:0] mem_wdata;
    logic [AW-1:0] slot;
    logic          digit_ok;
    logic [UW-1:0] used_ext;

    assign digit_ok = ({1'b0, i_digit} < 5'(RADIX));
    assign slot     = AW'(r_cursor) * AW'(RADIX) + AW'(i_digit);

    assign o_stat.clr_done    = (r_clr_addr == AW'(DEPTH - 1));
    assign o_stat.out_blocked = r_last && r_out_valid && i_out_stall;

    // one digit step of the walk
    always_comb begin
        n_cursor    = r_cursor;
        n_next_free = r_next_free;
        n_missed    = r_missed;
        n_ovf       = r_ovf;
        walk_we     = 1'b0;
        if (!r_missed && !r_ovf) begin
            if (!r_digit_ok) begin
                n_missed = 1'b1;
            end else if (r_rdata != '0) begin
                n_cursor = r_rdata;
            end else if (!r_mode) begin
                n_missed = 1'b1;
            end else if (r_next_free >= CW'(NODE_COUNT)) begin
                n_ovf = 1'b1;
            end else begin
                walk_we     = 1'b1;
                n_cursor    = r_next_free[NW-1:0];
                n_next_free = r_next_free + CW'(1);
            end
        end
    end

    assign used_ext  = UW'(n_next_free);
    assign mem_we    = i_cmd.clear || (i_cmd.resolve && walk_we);
    assign mem_waddr = i_cmd.clear ? r_clr_addr : r_slot;
    assign mem_wdata = i_cmd.clear ? '0 : r_next_free[NW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.accept) begin
            r_rdata <= mem[slot];
        end
    end

    // latched digit and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode     <= i_mode;
            r_last     <= i_last;
            r_digit_ok <= digit_ok;
            r_slot     <= slot;
        end
        if (i_cmd.resolve && r_last) begin
            r_out_found <= !(n_missed || n_ovf);
            r_out_full  <= n_ovf;
            r_out_used  <= used_ext[dtrie_pkg::USED_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor    <= '0;
            r_next_free <= CW'(1);
            r_missed    <= 1'b0;
            r_ovf       <= 1'b0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.resolve) begin
                r_next_free <= n_next_free;
                if (r_last) begin
                    r_cursor <= '0;
                    r_missed <= 1'b0;
                    r_ovf    <= 1'b0;
                end else begin
                    r_cursor <= n_cursor;
                    r_missed <= n_missed;
                    r_ovf    <= n_ovf;
                end
            end
            if (i_cmd.resolve && r_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_found      = r_out_found;
    assign o_pool_full  = r_out_full;
    assign o_nodes_used = r_out_used;

endmodule

[rtl/core/decimal_trie_insert_lookup_unit.sv]
// channel   direction  handshake                fields
// digits    in         i_in_valid / o_in_stall  i_mode, i_digit, i_last
// results   out        o_out_valid / i_out_stall o_found, o_pool_full, o_nodes_used
//
// each digit word goes through a child table read, then the resolve step
// that follows the child or allocates a node and writes it back
// after reset the child table is swept to zero, one entry a cycle, over all
// NODE_COUNT * RADIX entries (10240 by default) with the digit input stalled
// a result sits in an output register, so digits keep flowing while it waits;
// only a last digit that finds that register still full and stalled is held
module decimal_trie_insert_lookup_unit #(
    parameter int NODE_COUNT = 1024,
    parameter int RADIX      = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // digit words
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_mode,
    input  logic [dtrie_pkg::DIGIT_W-1:0] i_digit,
    input  logic                          i_last,
    // result words
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_found,
    output logic                          o_pool_full,
    output logic [dtrie_pkg::USED_W-1:0]  o_nodes_used
);

    dtrie_pkg::t_ctrl_cmd  cmd;
    dtrie_pkg::t_ctrl_stat stat;

    // sequencer: sweep, take a digit, resolve it
    dtrie_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // child table, walk state, allocator and result register
    dtrie_dpath #(
        .NODE_COUNT (NODE_COUNT),
        .RADIX      (RADIX)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_mode       (i_mode),
        .i_digit      (i_digit),
        .i_last       (i_last),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_found      (o_found),
        .o_pool_full  (o_pool_full),
        .o_nodes_used (o_nodes_used)
    );

    // a new result only ever appears right after a resolve step
    a_result_from_resolve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(cmd.resolve))
        else $error("result word without a resolve step");

    // an accepted digit always keeps the input stalled for its resolve cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.accept |=> o_in_stall)
        else $error("digit accepted while previous one unresolved");

    // an overflowed insert never reports the key as stored
    a_full_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_pool_full |-> !o_found)
        else $error("pool_full with found set");

    // no digit is taken during the clearing sweep
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear |-> o_in_stall && !cmd.resolve)
        else $error("activity during clearing sweep");

endmodule

[test/tb_decimal_trie_insert_lookup_unit.sv]
`timescale 1ns / 100ps

module tb_decimal_trie_insert_lookup_unit;

    localparam int NODE_COUNT = 1024;
    localparam int RADIX      = 10;
    localparam int MAX_KEY    = 16;
    // idle limit covers the clearing sweep over all 10240 table entries after reset several times
    localparam int IDLE_LIMIT = 40000;
    localparam int LONG_HOLD  = 300;
    localparam int DRAIN_WAIT = 20;

    typedef enum logic {
        MODE_LOOKUP = 1'b0,
        MODE_INSERT = 1'b1
    } t_trie_mode;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC
    } t_stall_style;

    // one result word as the block presents it
    typedef struct packed {
        logic                         found;
        logic                         pool_full;
        logic [dtrie_pkg::USED_W-1:0] nodes_used;
    } t_result_word;

    // a key that made it into the trie, kept for later lookups
    typedef struct packed {
        logic [4:0]       len;
        logic [15:0][3:0] digs;
    } t_stored_key;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic                          i_mode      = 1'b0;
    logic [dtrie_pkg::DIGIT_W-1:0] i_digit     = '0;
    logic                          i_last      = 1'b0;
    logic                          i_out_stall = 1'b0;
    logic                          o_in_stall;
    logic                          o_out_valid;
    logic                          o_found;
    logic                          o_pool_full;
    logic [dtrie_pkg::USED_W-1:0]  o_nodes_used;

    decimal_trie_insert_lookup_unit #(
        .NODE_COUNT (NODE_COUNT),
        .RADIX      (RADIX)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_digit      (i_digit),
        .i_last       (i_last),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_found      (o_found),
        .o_pool_full  (o_pool_full),
        .o_nodes_used (o_nodes_used)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // trie shadow: child index per (node, digit), zero means no child
    logic [9:0]    child_of [NODE_COUNT*RADIX];
    logic [10:0]   alloc_next;
    logic [9:0]    walk_node;
    logic          walk_missed;
    logic          walk_overflow;
    logic          last_key_found;

    t_result_word  expected_results[$];
    t_stored_key   stored_keys[$];
    logic [3:0]    key_buf [MAX_KEY];

    int            fail_count    = 0;
    int            digits_sent   = 0;
    int            burst_left    = 0;
    bit            gaps_on       = 1'b1;

    // long hold-off handshake between the test sequence and the receiver
    int            hold_requests = 0;
    int            hold_seen     = 0;
    int            hold_left     = 0;
    t_stall_style  stall_style   = STALL_NONE;
    int            pattern_left  = 0;
    int            pattern_phase = 0;
    int            idle_cycles   = 0;

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endfunction

    // advance the shadow trie by one accepted digit word, queue a result on the last digit
    function automatic void trie_predict(t_trie_mode mode, logic [3:0] dig, logic lst);
        int           slot;
        logic [9:0]   kid;
        t_result_word r;
        if (!walk_missed && !walk_overflow) begin
            if (dig >= RADIX) begin
                // out-of-range digit: key is dead, nothing read or allocated
                walk_missed = 1'b1;
            end else begin
                slot = walk_node * RADIX + dig;
                kid  = child_of[slot];
                if (kid == '0) begin
                    if (mode == MODE_LOOKUP) begin
                        walk_missed = 1'b1;
                    end else if (alloc_next >= NODE_COUNT) begin
                        walk_overflow = 1'b1;
                    end else begin
                        kid            = alloc_next[9:0];
                        alloc_next     = alloc_next + 11'd1;
                        child_of[slot] = kid;
                        walk_node      = kid;
                    end
                end else begin
                    walk_node = kid;
                end
            end
        end
        if (lst) begin
            r.found        = !(walk_missed || walk_overflow);
            r.pool_full    = walk_overflow;
            r.nodes_used   = alloc_next;
            expected_results.push_back(r);
            last_key_found = r.found;
            walk_node      = '0;
            walk_missed    = 1'b0;
            walk_overflow  = 1'b0;
        end
    endfunction

    // drive one digit word, hold it until taken, burst and gap control lives here
    task automatic send_digit(t_trie_mode mode, logic [3:0] dig, logic lst);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = (gaps_on && $urandom_range(0, 3) != 0) ? $urandom_range(1, 8) : 0;
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_digit    <= dig;
        i_last     <= lst;
        do @(posedge i_clk); while (o_in_stall);
        trie_predict(mode, dig, lst);
        digits_sent++;
    endtask

    task automatic send_key(t_trie_mode mode, int len);
        for (int i = 0; i < len; i++)
            send_digit(mode, key_buf[i], i == len - 1);
    endtask

    // copy a random stored key into the key buffer
    function automatic int pick_stored();
        t_stored_key k;
        k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        for (int i = 0; i < k.len; i++)
            key_buf[i] = k.digs[i];
        return int'(k.len);
    endfunction

    task automatic insert_fresh_key(int len);
        t_stored_key k;
        k = '0;
        for (int i = 0; i < len; i++)
            key_buf[i] = 4'($urandom_range(0, RADIX - 1));
        send_key(MODE_INSERT, len);
        if (last_key_found) begin
            k.len = 5'(len);
            for (int i = 0; i < len; i++)
                k.digs[i] = key_buf[i];
            stored_keys.push_back(k);
        end
    endtask

    // sender stops and waits until every queued result word has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // empty trie, extremes of the digit, prefixes, dead keys, mixed modes
    task automatic test_directed();
        // lookup on the empty trie misses
        send_digit(MODE_LOOKUP, 4'd5, 1'b1);
        // insert 0 9, then find it and its prefix
        send_digit(MODE_INSERT, 4'd0, 1'b0);
        send_digit(MODE_INSERT, 4'd9, 1'b1);
        send_digit(MODE_LOOKUP, 4'd0, 1'b0);
        send_digit(MODE_LOOKUP, 4'd9, 1'b1);
        send_digit(MODE_LOOKUP, 4'd0, 1'b1);
        // path runs out on the third digit
        send_digit(MODE_LOOKUP, 4'd0, 1'b0);
        send_digit(MODE_LOOKUP, 4'd9, 1'b0);
        send_digit(MODE_LOOKUP, 4'd3, 1'b1);
        // miss on the first digit, the rest of the key is ignored
        send_digit(MODE_LOOKUP, 4'd7, 1'b0);
        send_digit(MODE_LOOKUP, 4'd4, 1'b0);
        send_digit(MODE_LOOKUP, 4'd1, 1'b1);
        // out-of-range digit kills an insert halfway, the first node stays allocated
        send_digit(MODE_INSERT, 4'd1, 1'b0);
        send_digit(MODE_INSERT, 4'd15, 1'b0);
        send_digit(MODE_INSERT, 4'd2, 1'b1);
        send_digit(MODE_LOOKUP, 4'd10, 1'b1);
        // mode flips inside a key: lookup hit, insert on existing, insert new
        send_digit(MODE_LOOKUP, 4'd0, 1'b0);
        send_digit(MODE_INSERT, 4'd9, 1'b0);
        send_digit(MODE_INSERT, 4'd4, 1'b1);
        // lookup miss inside an insert key stops it for good
        send_digit(MODE_INSERT, 4'd3, 1'b0);
        send_digit(MODE_LOOKUP, 4'd6, 1'b0);
        send_digit(MODE_INSERT, 4'd2, 1'b1);
        // node from the dead key is still there
        send_digit(MODE_LOOKUP, 4'd3, 1'b1);
    endtask

    // mixed keys: fresh inserts, hits, near misses, repeats and noise
    task automatic test_random_traffic(int n_digits);
        int start;
        int pick;
        int len;
        int pos;
        start = digits_sent;
        while (digits_sent - start < n_digits) begin
            pick = $urandom_range(0, 99);
            if (pick < 35 || stored_keys.size() == 0) begin
                insert_fresh_key($urandom_range(1, 8));
            end else if (pick < 65) begin
                // whole key or a prefix of it
                len = pick_stored();
                send_key(MODE_LOOKUP, $urandom_range(1, len));
            end else if (pick < 75) begin
                len = pick_stored();
                if (len < MAX_KEY && $urandom_range(0, 1) == 1) begin
                    key_buf[len] = 4'($urandom_range(0, RADIX - 1));
                    len++;
                end else begin
                    pos = $urandom_range(0, len - 1);
                    key_buf[pos] = 4'((int'(key_buf[pos]) + $urandom_range(1, 9)) % RADIX);
                end
                send_key(MODE_LOOKUP, len);
            end else if (pick < 85) begin
                len = pick_stored();
                send_key(MODE_INSERT, len);
            end else begin
                // noise: any digit code, modes flipping per word
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    send_digit(t_trie_mode'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                               i == len - 1);
            end
        end
    endtask

    // receiver holds off for a long time while digits keep coming without gaps
    task automatic test_output_backpressure();
        gaps_on = 1'b0;
        hold_requests++;
        test_random_traffic(60);
        gaps_on = 1'b1;
        wait_drained();
    endtask

    // long fresh keys until the pool is gone, then a few keys that overflow
    task automatic test_pool_fill();
        while (alloc_next < NODE_COUNT)
            insert_fresh_key(MAX_KEY);
        repeat (6) insert_fresh_key($urandom_range(2, 6));
    endtask

    // receiver: check each taken result word, then pick the next stall value
    always @(posedge i_clk) begin
        t_result_word got;
        t_result_word exp_w;
        logic         stall_next;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got = '{found: o_found, pool_full: o_pool_full, nodes_used: o_nodes_used};
                if (expected_results.size() == 0) begin
                    note_failure($sformatf({"unexpected result word: found=%0b ",
                                            "pool_full=%0b nodes_used=%0d"},
                                           got.found, got.pool_full, got.nodes_used));
                end else begin
                    exp_w = expected_results.pop_front();
                    if (got.found !== exp_w.found || got.pool_full !== exp_w.pool_full ||
                        got.nodes_used !== exp_w.nodes_used)
                        note_failure($sformatf({"result word mismatch: expected found=%0b ",
                                                "pool_full=%0b nodes_used=%0d, got found=%0b ",
                                                "pool_full=%0b nodes_used=%0d"},
                                               exp_w.found, exp_w.pool_full, exp_w.nodes_used,
                                               got.found, got.pool_full, got.nodes_used));
                end
            end
            // long hold-off takes priority over the running pattern
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else begin
                if (pattern_left == 0) begin
                    stall_style  = t_stall_style'($urandom_range(0, 2));
                    pattern_left = $urandom_range(16, 96);
                end
                pattern_left--;
                pattern_phase++;
                case (stall_style)
                    STALL_NONE:     stall_next = 1'b0;
                    STALL_RANDOM:   stall_next = ($urandom_range(0, 99) < 40);
                    STALL_PERIODIC: stall_next = ((pattern_phase % 5) < 2);
                    default:        stall_next = 1'b0;
                endcase
            end
            i_out_stall <= stall_next;
        end
    end

    // watchdog: too long without any word moving on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        foreach (child_of[i])
            child_of[i] = '0;
        alloc_next     = 11'd1;
        walk_node      = '0;
        walk_missed    = 1'b0;
        walk_overflow  = 1'b0;
        last_key_found = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        wait_drained();
        test_random_traffic(250);
        wait_drained();
        test_output_backpressure();
        test_random_traffic(150);
        wait_drained();
        test_pool_fill();
        wait_drained();
        // pool is full now: hits, repeats and overflowing inserts
        test_random_traffic(120);
        wait_drained();

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
